/* rtl/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants and types for the raster line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // Transaction codes carried on the mode field
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Walk direction flags of a segment
  typedef struct packed {
    logic x_major;
    logic minor_down;
  } seg_flags_t;

endpackage

/* rtl/bresenham_line_stepper.sv */
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Raster line generator: one load transaction prepares a segment, each step
// transaction returns the next pixel of it.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): mode selects load (MODE_LOAD) or step
//   (MODE_STEP). A load takes start and end points, yields no pixel and
//   replaces any segment in progress. A step yields one pixel while the
//   segment has pixels left, and nothing once it is finished.
//   Output channel (out_valid/out_ready): pixel_x, pixel_y and last_pixel,
//   which is high on the final pixel of the segment.
//   An accepted step's pixel appears on the output register in the cycle
//   after acceptance. Throughput is one transaction per cycle while the
//   output is not stalled: the segment state and the output register both
//   update in the cycle of acceptance, by a compare, subtract and add on the error term.
//   in_ready is high while the output register is empty or being taken, so
//   a stalled receiver holds the input off after one pixel is waiting.
//   Reset clears the segment state; no line is loaded and the output is empty.
// ----------------------------------------------------------------------------
module bresenham_line_stepper
  import bls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  // Segment state
  logic [COORD_BITS-1:0]        walk_x;
  logic [COORD_BITS-1:0]        walk_y;
  logic signed [COORD_BITS+1:0] error_term;
  logic [COORD_BITS-1:0]        major_delta;
  logic [COORD_BITS-1:0]        minor_delta;
  logic [COORD_BITS:0]          steps_left;
  seg_flags_t                   flags;
  logic                         line_active;

  // Setup results
  logic [COORD_BITS-1:0]        ld_walk_x;
  logic [COORD_BITS-1:0]        ld_walk_y;
  logic [COORD_BITS-1:0]        ld_major;
  logic [COORD_BITS-1:0]        ld_minor;
  logic [COORD_BITS:0]          ld_steps;
  logic signed [COORD_BITS+1:0] ld_error;
  seg_flags_t                   ld_flags;

  // Step results
  logic [COORD_BITS-1:0]        walk_x_next;
  logic [COORD_BITS-1:0]        walk_y_next;
  logic [COORD_BITS:0]          steps_left_next;
  logic signed [COORD_BITS+1:0] error_term_next;
  logic                         last;

  logic accept;
  logic emit;

  bls_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .walk_x      (ld_walk_x),
    .walk_y      (ld_walk_y),
    .major_delta (ld_major),
    .minor_delta (ld_minor),
    .steps_left  (ld_steps),
    .error_term  (ld_error),
    .flags       (ld_flags)
  );

  bls_advance #(
    .COORD_BITS(COORD_BITS)
  ) u_advance (
    .walk_x          (walk_x),
    .walk_y          (walk_y),
    .major_delta     (major_delta),
    .minor_delta     (minor_delta),
    .steps_left      (steps_left),
    .error_term      (error_term),
    .flags           (flags),
    .walk_x_next     (walk_x_next),
    .walk_y_next     (walk_y_next),
    .steps_left_next (steps_left_next),
    .error_term_next (error_term_next),
    .last            (last)
  );

  // Accept while the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = accept && (mode == MODE_STEP) && line_active && (steps_left != '0);

  // Update the segment state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x      <= '0;
      walk_y      <= '0;
      error_term  <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      steps_left  <= '0;
      flags       <= '0;
      line_active <= 1'b0;
    end else if (accept) begin
      if (mode == MODE_LOAD) begin
        walk_x      <= ld_walk_x;
        walk_y      <= ld_walk_y;
        error_term  <= ld_error;
        major_delta <= ld_major;
        minor_delta <= ld_minor;
        steps_left  <= ld_steps;
        flags       <= ld_flags;
        line_active <= 1'b1;
      end else if (emit) begin
        steps_left <= steps_left_next;
        if (last) begin
          line_active <= 1'b0;
        end else begin
          walk_x     <= walk_x_next;
          walk_y     <= walk_y_next;
          error_term <= error_term_next;
        end
      end else begin
        line_active <= 1'b0;
      end
    end
  end

  // Hold the output valid until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the pixel payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= walk_x;
      pixel_y    <= walk_y;
      last_pixel <= last;
    end
  end

endmodule

/* rtl/bls_setup.sv */
// ----------------------------------------------------------------------------
// bls_setup
// Segment setup: orders the endpoints along the major axis and derives the
// deltas, initial error term and pixel count of a new segment.
// ----------------------------------------------------------------------------
module bls_setup
  import bls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic [COORD_BITS-1:0]   walk_x,
  output logic [COORD_BITS-1:0]   walk_y,
  output logic [COORD_BITS-1:0]   major_delta,
  output logic [COORD_BITS-1:0]   minor_delta,
  output logic [COORD_BITS:0]     steps_left,
  output logic signed [COORD_BITS+1:0] error_term,
  output seg_flags_t              flags
);

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] minor_raw;
  logic                  swap;
  logic                  aligned;

  // Absolute deltas on each axis
  assign adx = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
  assign ady = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);

  // Pick the major axis; ties go to x
  assign flags.x_major = (adx >= ady);
  assign swap = flags.x_major ? (end_x < start_x) : (end_y < start_y);

  // Start from the endpoint with the lower major coordinate
  assign walk_x = swap ? end_x : start_x;
  assign walk_y = swap ? end_y : start_y;
  assign flags.minor_down = flags.x_major ?
                            (swap ? (start_y < end_y) : (end_y < start_y)) :
                            (swap ? (start_x < end_x) : (end_x < start_x));

  assign major_delta = flags.x_major ? adx : ady;
  assign minor_raw   = flags.x_major ? ady : adx;

  // Axis-aligned segments keep the minor axis still and draw both ends
  assign aligned     = (adx == '0) || (ady == '0);
  assign minor_delta = aligned ? '0 : minor_raw;
  assign steps_left  = {1'b0, major_delta} + {{COORD_BITS{1'b0}}, aligned};

  assign error_term = $signed({2'b00, minor_delta}) - $signed({2'b00, major_delta});

endmodule

/* rtl/bls_advance.sv */
// ----------------------------------------------------------------------------
// bls_advance
// Pixel step: advances the walk by one pixel along the major axis, steps the
// minor axis when the error term is positive, and counts down the pixels.
// ----------------------------------------------------------------------------
module bls_advance
  import bls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]        walk_x,
  input  logic [COORD_BITS-1:0]        walk_y,
  input  logic [COORD_BITS-1:0]        major_delta,
  input  logic [COORD_BITS-1:0]        minor_delta,
  input  logic [COORD_BITS:0]          steps_left,
  input  logic signed [COORD_BITS+1:0] error_term,
  input  seg_flags_t                   flags,
  output logic [COORD_BITS-1:0]        walk_x_next,
  output logic [COORD_BITS-1:0]        walk_y_next,
  output logic [COORD_BITS:0]          steps_left_next,
  output logic signed [COORD_BITS+1:0] error_term_next,
  output logic                         last
);

  logic                        minor_step;
  logic [COORD_BITS-1:0]       minor_pos;
  logic [COORD_BITS-1:0]       minor_moved;
  logic signed [COORD_BITS+1:0] err_sub;

  // Count down the pixels still to give
  assign steps_left_next = steps_left - {{COORD_BITS{1'b0}}, 1'b1};
  assign last            = (steps_left_next == '0);

  // Step the minor axis while the error term is positive
  assign minor_step  = (error_term > 0);
  assign minor_pos   = flags.x_major ? walk_y : walk_x;
  assign minor_moved = !minor_step ? minor_pos :
                       flags.minor_down ? (minor_pos - {{(COORD_BITS-1){1'b0}}, 1'b1}) :
                                          (minor_pos + {{(COORD_BITS-1){1'b0}}, 1'b1});

  assign err_sub = minor_step ? (error_term - $signed({2'b00, major_delta})) : error_term;
  assign error_term_next = err_sub + $signed({2'b00, minor_delta});

  // Advance the major axis every pixel
  always_comb begin
    if (flags.x_major) begin
      walk_x_next = walk_x + {{(COORD_BITS-1){1'b0}}, 1'b1};
      walk_y_next = minor_moved;
    end else begin
      walk_x_next = minor_moved;
      walk_y_next = walk_y + {{(COORD_BITS-1){1'b0}}, 1'b1};
    end
  end

endmodule
